@@ hw/rtl/ir_pulse_distance_transmitter_assert.svh @@
// Assertion macros for the infrared pulse-distance transmitter checks
`ifndef IR_PULSE_DISTANCE_TRANSMITTER_ASSERT_SVH
`define IR_PULSE_DISTANCE_TRANSMITTER_ASSERT_SVH

// checked only outside reset
`define IPDT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked during reset as well
`define IPDT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hw/rtl/ipdt_pkg.sv @@
// Shared types, codes and helpers of the infrared pulse-distance transmitter
package ipdt_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CARRIER_HIGH = 3'd0,
        CFG_CARRIER_LOW  = 3'd1,
        CFG_BURST_PULSES = 3'd2,
        CFG_ZERO_GAP     = 3'd3,
        CFG_ONE_GAP      = 3'd4,
        CFG_FRAME_GAP    = 3'd5
    } t_cfg_index;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SEND = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HIGH      = 3'd1,
        PH_LOW       = 3'd2,
        PH_GAP       = 3'd3,
        PH_FRAME_GAP = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0]  carrier_high;
        logic [7:0]  carrier_low;
        logic [7:0]  burst_pulses;
        logic [15:0] zero_gap;
        logic [15:0] one_gap;
        logic [15:0] frame_gap;
    } t_cfg;

    typedef struct packed {
        logic ir_led;
        logic busy_res;
        logic accepted;
        logic done_res;
    } t_result;

    function automatic logic [7:0] at_least_one_8(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic logic [15:0] at_least_one_16(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

@@ hw/rtl/ipdt_cfg_regs.sv @@
// Timing configuration registers, stored with zero counts raised to one
module ipdt_cfg_regs
    import ipdt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CARRIER_HIGH: n_cfg.carrier_high = at_least_one_8(i_cfg_data[7:0]);
                CFG_CARRIER_LOW:  n_cfg.carrier_low  = at_least_one_8(i_cfg_data[7:0]);
                CFG_BURST_PULSES: n_cfg.burst_pulses = at_least_one_8(i_cfg_data[7:0]);
                CFG_ZERO_GAP:     n_cfg.zero_gap     = at_least_one_16(i_cfg_data);
                CFG_ONE_GAP:      n_cfg.one_gap      = at_least_one_16(i_cfg_data);
                CFG_FRAME_GAP:    n_cfg.frame_gap    = at_least_one_16(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.carrier_high <= 8'd13;
            r_cfg.carrier_low  <= 8'd12;
            r_cfg.burst_pulses <= 8'd12;
            r_cfg.zero_gap     <= 16'd680;
            r_cfg.one_gap      <= 16'd1680;
            r_cfg.frame_gap    <= 16'd40000;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/ipdt_core.sv @@
// Frame sequencer: phase, counters, latched payload and LED level
module ipdt_core
    import ipdt_pkg::*;
#(
    parameter int ADDRESS_BITS = 5,
    parameter int COMMAND_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_req_type,
    input  logic [4:0] i_address,
    input  logic [7:0] i_command,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    localparam int DATA_BITS = ADDRESS_BITS + COMMAND_BITS + 2;
    localparam int BIT_W     = $clog2(DATA_BITS + 1);
    localparam int IDX_W     = $clog2(DATA_BITS);

    t_phase                  r_phase, n_phase;
    logic [BIT_W-1:0]        r_bit_count, n_bit_count;
    logic [7:0]              r_pulse_count, n_pulse_count;
    logic [15:0]             r_tick_count, n_tick_count;
    logic [ADDRESS_BITS-1:0] r_saved_address, n_saved_address;
    logic [COMMAND_BITS-1:0] r_saved_command, n_saved_command;
    logic                    r_second_frame, n_second_frame;
    logic                    r_led, n_led;
    logic                    n_accepted, n_done;

    logic [15:0]          w_tick_inc;
    logic [7:0]           w_pulse_inc;
    logic [DATA_BITS-1:0] w_frame_word;
    logic [BIT_W-1:0]     w_bit_idx;
    logic                 w_frame_bit;
    logic [15:0]          w_gap_len;
    logic                 w_high_end, w_low_end, w_pulse_end, w_gap_end, w_fgap_end;
    logic                 w_more_bits;

    assign w_tick_inc   = r_tick_count + 16'd1;
    assign w_pulse_inc  = r_pulse_count + 8'd1;
    assign w_frame_word = {r_saved_address,
                           r_saved_command ^ {COMMAND_BITS{r_second_frame}},
                           ~r_second_frame, r_second_frame};
    assign w_bit_idx    = BIT_W'(DATA_BITS - 1) - r_bit_count;
    assign w_frame_bit  = w_frame_word[w_bit_idx[IDX_W-1:0]];
    assign w_gap_len    = w_frame_bit ? i_cfg.one_gap : i_cfg.zero_gap;
    assign w_high_end   = w_tick_inc >= {8'd0, i_cfg.carrier_high};
    assign w_low_end    = w_tick_inc >= {8'd0, i_cfg.carrier_low};
    assign w_pulse_end  = w_pulse_inc >= i_cfg.burst_pulses;
    assign w_gap_end    = w_tick_inc >= w_gap_len;
    assign w_fgap_end   = w_tick_inc >= i_cfg.frame_gap;
    assign w_more_bits  = r_bit_count < BIT_W'(DATA_BITS);

    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (i_req_type == REQ_SEND) begin
                if (r_phase == PH_IDLE) begin
                    n_phase = PH_HIGH;
                end
            end else begin
                unique case (r_phase)
                    PH_HIGH: begin
                        if (w_high_end) n_phase = PH_LOW;
                    end
                    PH_LOW: begin
                        if (w_low_end) begin
                            if (!w_pulse_end) begin
                                n_phase = PH_HIGH;
                            end else if (w_more_bits) begin
                                n_phase = PH_GAP;
                            end else if (!r_second_frame) begin
                                n_phase = PH_FRAME_GAP;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                    PH_GAP: begin
                        if (w_gap_end) n_phase = PH_HIGH;
                    end
                    PH_FRAME_GAP: begin
                        if (w_fgap_end) n_phase = PH_HIGH;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        n_bit_count     = r_bit_count;
        n_pulse_count   = r_pulse_count;
        n_tick_count    = r_tick_count;
        n_saved_address = r_saved_address;
        n_saved_command = r_saved_command;
        n_second_frame  = r_second_frame;
        n_led           = r_led;
        n_accepted      = 1'b0;
        n_done          = 1'b0;
        if (i_accept) begin
            if (i_req_type == REQ_SEND) begin
                if (r_phase == PH_IDLE) begin
                    n_saved_address = ADDRESS_BITS'(i_address);
                    n_saved_command = COMMAND_BITS'(i_command);
                    n_second_frame  = 1'b0;
                    n_bit_count     = '0;
                    n_pulse_count   = 8'd0;
                    n_tick_count    = 16'd0;
                    n_accepted      = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    PH_HIGH: begin
                        n_led        = 1'b1;
                        n_tick_count = w_high_end ? 16'd0 : w_tick_inc;
                    end
                    PH_LOW: begin
                        n_led        = 1'b0;
                        n_tick_count = w_low_end ? 16'd0 : w_tick_inc;
                        if (w_low_end) begin
                            n_pulse_count = w_pulse_end ? 8'd0 : w_pulse_inc;
                            if (w_pulse_end && !w_more_bits && r_second_frame) begin
                                n_bit_count    = '0;
                                n_second_frame = 1'b0;
                                n_done         = 1'b1;
                            end
                        end
                    end
                    PH_GAP: begin
                        n_led        = 1'b0;
                        n_tick_count = w_gap_end ? 16'd0 : w_tick_inc;
                        if (w_gap_end) n_bit_count = r_bit_count + BIT_W'(1);
                    end
                    PH_FRAME_GAP: begin
                        n_led        = 1'b0;
                        n_tick_count = w_fgap_end ? 16'd0 : w_tick_inc;
                        if (w_fgap_end) begin
                            n_bit_count    = '0;
                            n_second_frame = 1'b1;
                        end
                    end
                    default: n_led = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_bit_count    <= '0;
            r_pulse_count  <= 8'd0;
            r_tick_count   <= 16'd0;
            r_second_frame <= 1'b0;
            r_led          <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_bit_count    <= n_bit_count;
            r_pulse_count  <= n_pulse_count;
            r_tick_count   <= n_tick_count;
            r_second_frame <= n_second_frame;
            r_led          <= n_led;
        end
    end

    always_ff @(posedge i_clk) begin
        r_saved_address <= n_saved_address;
        r_saved_command <= n_saved_command;
    end

    always_comb begin
        o_result.ir_led   = n_led;
        o_result.busy_res = (n_phase != PH_IDLE);
        o_result.accepted = n_accepted;
        o_result.done_res = n_done;
    end

endmodule

@@ hw/rtl/ipdt_out_queue.sv @@
// Two-entry result queue between the sequencer and the output channel
module ipdt_out_queue
    import ipdt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    t_result    r_entry [2];
    logic       r_rd_ptr, n_rd_ptr;
    logic       r_wr_ptr, n_wr_ptr;
    logic [1:0] r_count, n_count;
    logic       w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign w_pop   = o_valid && !i_stall;
    assign o_data  = r_entry[r_rd_ptr];

    always_comb begin
        n_rd_ptr = w_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/ir_pulse_distance_transmitter.sv @@
// Top level of the infrared pulse-distance transmitter
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in      | in        | i_in_valid / o_in_stall | i_req_type, i_address, i_command
//  out     | out       | o_out_valid / i_out_stall | o_ir_led, o_busy_res, o_accepted, o_done_res
//  cfg     | in        | i_cfg_we               | i_cfg_index, i_cfg_data
//
// One item per cycle while o_in_stall is low: the sequencer updates its state in the cycle of the transfer.
// Its result is registered in a two-entry queue on its way to the output.
// o_in_stall rises only while both queue entries are occupied, which a stalled output brings about.
// Reset (synchronous, low) loads the register defaults and empties the queue.
module ir_pulse_distance_transmitter
    import ipdt_pkg::*;
#(
    parameter int ADDRESS_BITS = 5,
    parameter int COMMAND_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_req_type,
    input  logic [4:0]             i_address,
    input  logic [7:0]             i_command,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_ir_led,
    output logic                   o_busy_res,
    output logic                   o_accepted,
    output logic                   o_done_res
);

    t_cfg    w_cfg;
    t_result w_result;
    t_result w_out;
    logic    w_full;
    logic    w_accept;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    ipdt_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    ipdt_core #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .COMMAND_BITS (COMMAND_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_req_type (i_req_type),
        .i_address  (i_address),
        .i_command  (i_command),
        .i_cfg      (w_cfg),
        .o_result   (w_result)
    );

    ipdt_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_out)
    );

    assign o_ir_led   = w_out.ir_led;
    assign o_busy_res = w_out.busy_res;
    assign o_accepted = w_out.accepted;
    assign o_done_res = w_out.done_res;

endmodule

@@ hw/rtl/ipdt_checker.sv @@
// Port-level checks of the infrared pulse-distance transmitter, bound to the top level
`include "ir_pulse_distance_transmitter_assert.svh"

module ipdt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_ir_led,
    input logic o_busy_res,
    input logic o_accepted,
    input logic o_done_res
);

    logic [3:0] w_out_word;
    logic       w_held;
    logic       w_acc;
    logic       w_done;
    logic       w_lit;

    assign w_out_word = {o_ir_led, o_busy_res, o_accepted, o_done_res};
    assign w_held     = o_out_valid && i_out_stall;
    assign w_acc      = o_out_valid && o_accepted;
    assign w_done     = o_out_valid && o_done_res;
    assign w_lit      = o_out_valid && o_ir_led;

    `IPDT_ASSERT(a_out_hold, w_held |=> o_out_valid && $stable(w_out_word), "held result changed")
    `IPDT_ASSERT(a_accept_busy, w_acc |-> o_busy_res && !o_done_res, "accepted send not busy")
    `IPDT_ASSERT(a_done_idle, w_done |-> !o_busy_res && !o_ir_led, "done while busy or lit")
    `IPDT_ASSERT(a_led_busy, w_lit |-> o_busy_res, "led lit while idle")
    `IPDT_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind ir_pulse_distance_transmitter ipdt_checker u_checker (.*);

@@ tb/ir_pulse_distance_transmitter_tb.sv @@
// Self-checking testbench of the infrared pulse-distance transmitter
module ir_pulse_distance_transmitter_tb;
    import ipdt_pkg::*;

    localparam int ADDR_W      = 5;
    localparam int CMD_W       = 8;
    localparam int FRAME_BITS  = ADDR_W + CMD_W + 2;
    localparam int HOLD_CYCLES = 100;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_req_type;
    logic [4:0]             i_address;
    logic [7:0]             i_command;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_ir_led;
    logic                   o_busy_res;
    logic                   o_accepted;
    logic                   o_done_res;

    ir_pulse_distance_transmitter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_address   (i_address),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ir_led    (o_ir_led),
        .o_busy_res  (o_busy_res),
        .o_accepted  (o_accepted),
        .o_done_res  (o_done_res)
    );

    // transmitter state as it should be after each transfer
    t_cfg            model_cfg;
    t_phase          tx_phase;
    logic [4:0]      bit_idx;
    logic [7:0]      pulse_cnt;
    logic [15:0]     tick_cnt;
    logic [4:0]      lat_address;
    logic [7:0]      lat_command;
    logic            in_second_frame;
    logic            led_on;

    t_result         led_status_due[$];
    bit              idling_on   = 1'b1;
    bit              hold_output = 1'b0;
    int              err_count   = 0;
    int              n_checked   = 0;
    int              n_done      = 0;
    int              n_refused   = 0;
    int              n_settings  = 1;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("ir_pulse_distance_transmitter test failed");
        $finish;
    end

    function automatic int floor_one(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic logic gap_bit(input logic [4:0] idx);
        int i;
        i = idx;
        if (i < ADDR_W)
            return lat_address[ADDR_W - 1 - i];
        i = i - ADDR_W;
        if (i < CMD_W)
            return lat_command[CMD_W - 1 - i] ^ in_second_frame;
        if (i == CMD_W)
            return ~in_second_frame;
        return in_second_frame;
    endfunction

    function automatic void reset_transmitter_model();
        model_cfg       = t_cfg'{8'd13, 8'd12, 8'd12, 16'd680, 16'd1680, 16'd40000};
        tx_phase        = PH_IDLE;
        bit_idx         = '0;
        pulse_cnt       = '0;
        tick_cnt        = '0;
        lat_address     = '0;
        lat_command     = '0;
        in_second_frame = 1'b0;
        led_on          = 1'b0;
    endfunction

    function automatic t_result advance_transmitter(input logic req, input logic [4:0] addr,
                                                    input logic [7:0] cmd);
        t_result res;
        int      gap_len;
        res = '0;
        if (req == REQ_SEND) begin
            if (tx_phase == PH_IDLE) begin
                lat_address     = addr;
                lat_command     = cmd;
                in_second_frame = 1'b0;
                bit_idx         = '0;
                pulse_cnt       = '0;
                tick_cnt        = '0;
                tx_phase        = PH_HIGH;
                res.accepted    = 1'b1;
            end
        end else begin
            case (tx_phase)
                PH_HIGH: begin
                    led_on   = 1'b1;
                    tick_cnt = tick_cnt + 16'd1;
                    if (int'(tick_cnt) >= floor_one(int'(model_cfg.carrier_high))) begin
                        tick_cnt = '0;
                        tx_phase = PH_LOW;
                    end
                end
                PH_LOW: begin
                    led_on   = 1'b0;
                    tick_cnt = tick_cnt + 16'd1;
                    if (int'(tick_cnt) >= floor_one(int'(model_cfg.carrier_low))) begin
                        tick_cnt  = '0;
                        pulse_cnt = pulse_cnt + 8'd1;
                        if (int'(pulse_cnt) >= floor_one(int'(model_cfg.burst_pulses))) begin
                            pulse_cnt = '0;
                            if (int'(bit_idx) < FRAME_BITS) begin
                                tx_phase = PH_GAP;
                            end else if (!in_second_frame) begin
                                tx_phase = PH_FRAME_GAP;
                            end else begin
                                tx_phase        = PH_IDLE;
                                bit_idx         = '0;
                                in_second_frame = 1'b0;
                                res.done_res    = 1'b1;
                            end
                        end else begin
                            tx_phase = PH_HIGH;
                        end
                    end
                end
                PH_GAP: begin
                    gap_len  = gap_bit(bit_idx) ? int'(model_cfg.one_gap)
                                                : int'(model_cfg.zero_gap);
                    led_on   = 1'b0;
                    tick_cnt = tick_cnt + 16'd1;
                    if (int'(tick_cnt) >= floor_one(gap_len)) begin
                        tick_cnt = '0;
                        bit_idx  = bit_idx + 5'd1;
                        tx_phase = PH_HIGH;
                    end
                end
                PH_FRAME_GAP: begin
                    led_on   = 1'b0;
                    tick_cnt = tick_cnt + 16'd1;
                    if (int'(tick_cnt) >= floor_one(int'(model_cfg.frame_gap))) begin
                        tick_cnt        = '0;
                        bit_idx         = '0;
                        in_second_frame = 1'b1;
                        tx_phase        = PH_HIGH;
                    end
                end
                default: begin
                    led_on   = 1'b0;
                    tx_phase = PH_IDLE;
                end
            endcase
        end
        res.ir_led   = led_on;
        res.busy_res = (tx_phase != PH_IDLE);
        return res;
    endfunction

    // output side: random hold-offs, and one long hold on request
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
                i_out_stall <= 1'b0;
            end else if (idling_on && $urandom_range(0, 15) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (led_status_due.size() == 0) begin
                $error("unexpected result transfer: ir_led %0b busy_res %0b %s %0b %s %0b",
                       o_ir_led, o_busy_res, "accepted", o_accepted, "done_res", o_done_res);
                err_count++;
            end else begin
                want = led_status_due.pop_front();
                n_checked++;
                if (o_ir_led !== want.ir_led) begin
                    $error("ir_led: expected %0b, got %0b", want.ir_led, o_ir_led);
                    err_count++;
                end
                if (o_busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0b, got %0b", want.busy_res, o_busy_res);
                    err_count++;
                end
                if (o_accepted !== want.accepted) begin
                    $error("accepted: expected %0b, got %0b", want.accepted, o_accepted);
                    err_count++;
                end
                if (o_done_res !== want.done_res) begin
                    $error("done_res: expected %0b, got %0b", want.done_res, o_done_res);
                    err_count++;
                end
                if (want.done_res)
                    n_done++;
            end
        end
    end

    task automatic push_item(input logic req, input logic [4:0] addr, input logic [7:0] cmd);
        t_result want;
        if (idling_on && $urandom_range(0, 15) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_address  <= addr;
        i_command  <= cmd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = advance_transmitter(req, addr, cmd);
        if (req == REQ_SEND && !want.accepted)
            n_refused++;
        led_status_due.push_back(want);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (led_status_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_regs(input t_cfg c);
        t_cfg_index            reg_sel[6];
        logic [CFG_DATA_W-1:0] reg_val[6];
        reg_sel = '{CFG_CARRIER_HIGH, CFG_CARRIER_LOW, CFG_BURST_PULSES,
                    CFG_ZERO_GAP, CFG_ONE_GAP, CFG_FRAME_GAP};
        // junk in the unused upper byte of the narrow registers
        reg_val = '{{8'($urandom), c.carrier_high}, {8'($urandom), c.carrier_low},
                    {8'($urandom), c.burst_pulses}, c.zero_gap, c.one_gap, c.frame_gap};
        for (int i = 0; i < 6; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= reg_sel[i];
            i_cfg_data  <= reg_val[i];
            @(posedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        model_cfg = c;
        n_settings++;
    endtask

    task automatic tick_n(input int n);
        repeat (n) push_item(REQ_TICK, 5'($urandom), 8'($urandom));
    endtask

    task automatic tick_until(input t_phase ph);
        while (tx_phase != ph && tx_phase != PH_IDLE)
            push_item(REQ_TICK, 5'($urandom), 8'($urandom));
    endtask

    task automatic finish_transmission();
        while (tx_phase != PH_IDLE) begin
            if ($urandom_range(0, 63) == 0)
                push_item(REQ_SEND, 5'($urandom), 8'($urandom));
            else
                push_item(REQ_TICK, 5'($urandom), 8'($urandom));
        end
    endtask

    task automatic run_transmission(input logic [4:0] addr, input logic [7:0] cmd);
        push_item(REQ_SEND, addr, cmd);
        finish_transmission();
    endtask

    task automatic test_reset_defaults();
        push_item(REQ_TICK, 5'h1F, 8'hFF);
        push_item(REQ_SEND, 5'h15, 8'hA5);
        tick_n(30);
        wait_drained();
        write_regs(t_cfg'{8'd1, 8'd1, 8'd1, 16'd1, 16'd2, 16'd1});
        finish_transmission();
        wait_drained();
    endtask

    task automatic test_directed_cases();
        write_regs(t_cfg'{8'd0, 8'd0, 8'd0, 16'd0, 16'd2, 16'd0});
        push_item(REQ_SEND, 5'h1F, 8'hFF);
        // refused: still busy with the first send
        run_transmission(5'h00, 8'h00);
        push_item(REQ_TICK, 5'h00, 8'h00);
        wait_drained();
    endtask

    task automatic test_long_counts();
        write_regs(t_cfg'{8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        push_item(REQ_SEND, 5'($urandom), 8'($urandom));
        tick_n(20);
        wait_drained();
        write_regs(t_cfg'{8'd1, 8'd1, 8'd1, 16'd1, 16'd2, 16'hFFFF});
        tick_until(PH_FRAME_GAP);
        tick_n(20);
        wait_drained();
        write_regs(t_cfg'{8'd1, 8'd1, 8'd1, 16'd1, 16'd2, 16'd1});
        finish_transmission();
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_regs(t_cfg'{8'd1, 8'd1, 8'd1, 16'd1, 16'd2, 16'd1});
        idling_on   = 1'b0;
        hold_output = 1'b1;
        run_transmission(5'($urandom), 8'($urandom));
        idling_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int counted;
        write_regs(t_cfg'{8'($urandom_range(0, 1)), 8'($urandom_range(0, 1)),
                          8'($urandom_range(0, 1)), 16'($urandom_range(0, 3)),
                          16'($urandom_range(0, 3)), 16'($urandom_range(0, 4))});
        counted = 0;
        while (counted < 80 || tx_phase != PH_IDLE) begin
            if (counted >= 40)
                idling_on = 1'b0;
            if (tx_phase == PH_IDLE) begin
                if ($urandom_range(0, 3) == 0) begin
                    push_item(REQ_SEND, 5'($urandom), 8'($urandom));
                    counted++;
                end else begin
                    push_item(REQ_TICK, 5'($urandom), 8'($urandom));
                end
            end else if ($urandom_range(0, 19) == 0) begin
                push_item(REQ_SEND, 5'($urandom), 8'($urandom));
            end else begin
                push_item(REQ_TICK, 5'($urandom), 8'($urandom));
                counted++;
            end
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_CARRIER_HIGH;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_req_type  <= REQ_TICK;
        i_address   <= '0;
        i_command   <= '0;
        reset_transmitter_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_cases();
        test_long_counts();
        test_backpressure();
        test_random_traffic();

        repeat (8) @(posedge i_clk);
        $display("Run covered %0d complete transmissions over %0d register settings,",
                 n_done, n_settings);
        $display("%0d LED/status results checked, %0d sends refused while busy",
                 n_checked, n_refused);
        if (err_count == 0 && led_status_due.size() == 0)
            $display("ir_pulse_distance_transmitter test passed");
        else
            $display("ir_pulse_distance_transmitter test failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ipdt_pkg.sv
hw/rtl/ipdt_cfg_regs.sv
hw/rtl/ipdt_core.sv
hw/rtl/ipdt_out_queue.sv
hw/rtl/ir_pulse_distance_transmitter.sv
hw/rtl/ipdt_checker.sv
tb/ir_pulse_distance_transmitter_tb.sv
